// File: rtl/its_pkg.sv
// shared types, widths and register codes of the interpolated table sampler
`default_nettype none

package its_pkg;

	// defaults of the top-level parameters
	localparam int DEF_MAX_ENTRIES = 1024;
	localparam int DEF_VALUE_BITS  = 16;

	// field widths
	localparam int WL_W        = 16;
	localparam int ENTRY_IDX_W = 10;
	localparam int LOAD_W      = 16;
	localparam int SAMPLE_W    = 16;
	localparam int COUNT_W     = 11;
	localparam int SCALE_W     = 24;
	localparam int CLAMP_W     = 2;

	// stream words
	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 48;

	// fractional index: diff * scale, 19 fraction bits
	localparam int PROD_W    = WL_W + SCALE_W;
	localparam int FRAC_BITS = 19;
	localparam int IPART_W   = PROD_W - FRAC_BITS;

	// configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 24;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_START = 2'd0,
		REG_END   = 2'd1,
		REG_COUNT = 2'd2,
		REG_SCALE = 2'd3
	} cfg_reg_t;

	localparam logic [WL_W-1:0]    RST_START = 16'd23040;
	localparam logic [WL_W-1:0]    RST_END   = 16'd53120;
	localparam logic [COUNT_W-1:0] RST_COUNT = 11'd471;
	localparam logic [SCALE_W-1:0] RST_SCALE = 24'd524288;

	// item kinds carried in tuser
	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	typedef enum logic [CLAMP_W-1:0] {
		CLAMP_NONE  = 2'd0,
		CLAMP_BELOW = 2'd1,
		CLAMP_LAST  = 2'd2
	} clamp_t;

endpackage

`default_nettype wire

// File: rtl/interpolated_table_sampler_unit.sv
// interpolated three-channel table sampler: top level and index pipeline
// a sample word passes stages 1 to 4 and the output register to m_axis_tvalid
// throughput: one word per cycle, loads and samples alike, when m_axis_tready
//   is high; a bubble in any stage is filled while the output register waits
// a load writes its entry when it leaves stage 2, where samples read the table
// reset clears the stage valid bits and loads the register defaults; the
//   table itself is not cleared and holds nothing until loaded
`default_nettype none

module interpolated_table_sampler_unit #(
	parameter int MAX_ENTRIES = its_pkg::DEF_MAX_ENTRIES,
	parameter int VALUE_BITS  = its_pkg::DEF_VALUE_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [its_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [its_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// wavelength, entry_index, load_x, load_y, load_z, zero pad
	input  wire logic [its_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// kind
	input  wire logic                             s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// sample_x, sample_y, sample_z
	output logic      [its_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// clamp_case
	output logic      [its_pkg::CLAMP_W-1:0]      m_axis_tuser
);

	import its_pkg::*;

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int RW = 3 * VALUE_BITS;

	// configuration registers
	logic [WL_W-1:0]    start_q;
	logic [WL_W-1:0]    end_q;
	logic [COUNT_W-1:0] count_q;
	logic [SCALE_W-1:0] scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= RST_START;
			end_q   <= RST_END;
			count_q <= RST_COUNT;
			scale_q <= RST_SCALE;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_START: start_q <= cfg_data[WL_W-1:0];
				REG_END:   end_q   <= cfg_data[WL_W-1:0];
				REG_COUNT: count_q <= cfg_data[COUNT_W-1:0];
				REG_SCALE: scale_q <= cfg_data[SCALE_W-1:0];
			endcase
		end
	end

	// last entry in use: count saturated to the table, zero taken as one
	logic [AW-1:0] last;

	always_comb begin
		if (32'(count_q) >= MAX_ENTRIES) begin
			last = AW'(MAX_ENTRIES - 1);
		end else if (count_q == '0) begin
			last = '0;
		end else begin
			last = AW'(count_q - COUNT_W'(1));
		end
	end

	// input word fields
	logic [WL_W-1:0]        in_wl;
	logic [ENTRY_IDX_W-1:0] in_entry;
	logic [LOAD_W-1:0]      in_x;
	logic [LOAD_W-1:0]      in_y;
	logic [LOAD_W-1:0]      in_z;

	assign in_wl    = s_axis_tdata[15:0];
	assign in_entry = s_axis_tdata[25:16];
	assign in_x     = s_axis_tdata[41:26];
	assign in_y     = s_axis_tdata[57:42];
	assign in_z     = s_axis_tdata[73:58];

	// stage enables: a stage moves when it is empty or the next one moves
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic en1, en2, en3, en4, en_o;

	assign en_o = !out_valid_q || m_axis_tready;
	assign en4  = !v_s4 || en_o;
	assign en3  = !v_s3 || en4;
	assign en2  = !v_s2 || en3;
	assign en1  = !v_s1 || en2;
	assign s_axis_tready = en1;

	// stage 1: range tests and offset from start
	logic                   kind_s1, below_s1, above_s1;
	logic [WL_W-1:0]        diff_s1;
	logic [ENTRY_IDX_W-1:0] entry_s1;
	logic [LOAD_W-1:0]      x_s1, y_s1, z_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			kind_s1  <= s_axis_tuser;
			below_s1 <= in_wl < start_q;
			above_s1 <= in_wl > end_q;
			diff_s1  <= in_wl - start_q;
			entry_s1 <= in_entry;
			x_s1     <= in_x;
			y_s1     <= in_y;
			z_s1     <= in_z;
		end
	end

	// stage 2: fractional index product
	logic                   kind_s2, below_s2, above_s2;
	logic [PROD_W-1:0]      prod_s2;
	logic [ENTRY_IDX_W-1:0] entry_s2;
	logic [LOAD_W-1:0]      x_s2, y_s2, z_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			kind_s2  <= kind_s1;
			below_s2 <= below_s1;
			above_s2 <= above_s1;
			prod_s2  <= PROD_W'(diff_s1) * PROD_W'(scale_q);
			entry_s2 <= entry_s1;
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			z_s2     <= z_s1;
		end
	end

	// stage 3: clamp decision, table read and load write
	logic [IPART_W-1:0] ipart;
	logic [AW-1:0]      addr_a, addr_b;
	clamp_t             code_c;
	logic               ram_we;
	logic [RW-1:0]      ram_wdata;
	logic [RW-1:0]      rd_a_s3, rd_b_s3;
	logic [FRAC_BITS-1:0] t_s3;
	clamp_t             code_s3;

	assign ipart = prod_s2[FRAC_BITS +: IPART_W];

	always_comb begin
		priority if (below_s2) begin
			code_c = CLAMP_BELOW;
			addr_a = '0;
			addr_b = '0;
		end else if (above_s2 || ipart >= IPART_W'(last)) begin
			code_c = CLAMP_LAST;
			addr_a = last;
			addr_b = last;
		end else begin
			code_c = CLAMP_NONE;
			addr_a = AW'(ipart);
			addr_b = AW'(ipart) + AW'(1);
		end
	end

	assign ram_we = en3 && v_s2 && kind_s2 == KIND_LOAD
		&& 32'(entry_s2) < MAX_ENTRIES;
	assign ram_wdata = {VALUE_BITS'(z_s2), VALUE_BITS'(y_s2), VALUE_BITS'(x_s2)};

	its_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_ENTRIES)
	) u_table (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (AW'(entry_s2)),
		.wdata   (ram_wdata),
		.re      (en3),
		.raddr_a (addr_a),
		.raddr_b (addr_b),
		.rdata_a (rd_a_s3),
		.rdata_b (rd_b_s3)
	);

	// clamped results blend with zero weight, which returns entry a exactly
	always_ff @(posedge clk) begin
		if (en3) begin
			code_s3 <= code_c;
			t_s3    <= (code_c == CLAMP_NONE) ? prod_s2[FRAC_BITS-1:0] : '0;
		end
	end

	// stages 4 and output: blend products, then rounded sum
	clamp_t code_s4;
	clamp_t code_q;
	logic [VALUE_BITS-1:0] res [3];

	always_ff @(posedge clk) begin
		if (en4) begin
			code_s4 <= code_s3;
		end
		if (en_o) begin
			code_q <= code_s4;
		end
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_chan
		its_blend #(
			.VALUE_BITS (VALUE_BITS)
		) u_blend (
			.clk    (clk),
			.en_mul (en4),
			.en_sum (en_o),
			.a      (rd_a_s3[ch*VALUE_BITS +: VALUE_BITS]),
			.b      (rd_b_s3[ch*VALUE_BITS +: VALUE_BITS]),
			.t      (t_s3),
			.res    (res[ch])
		);
	end

	// valid bits; loads leave the pipe once written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= s_axis_tvalid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2 && kind_s2 == KIND_SAMPLE;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
			if (en_o) begin
				out_valid_q <= v_s4;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {SAMPLE_W'(res[2]), SAMPLE_W'(res[1]), SAMPLE_W'(res[0])};
	assign m_axis_tuser  = code_q;

	// a sample leaving stage 2 always reaches stage 3
	a_sample_kept: assert property (@(posedge clk) disable iff (!arst_n)
		en3 && v_s2 && kind_s2 == KIND_SAMPLE |=> v_s3)
		else $error("sample word lost at table read");

	// a load never turns into a result
	a_load_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		en3 && v_s2 && kind_s2 == KIND_LOAD |=> !v_s3)
		else $error("load word passed the table stage");

	// clamped words carry zero blend weight
	a_clamp_weight: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && code_s3 != CLAMP_NONE |-> t_s3 == '0)
		else $error("clamped word with nonzero weight");

	// an empty first stage always takes a word
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> s_axis_tready)
		else $error("input stalled with stage 1 empty");

endmodule

`default_nettype wire

// File: rtl/its_ram.sv
// generic ram: one write port, two registered read ports
`default_nettype none

module its_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

// File: rtl/its_blend.sv
// two-stage linear blend of one channel, round half up
`default_nettype none

module its_blend #(
	parameter int VALUE_BITS = its_pkg::DEF_VALUE_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           en_mul,
	input  wire logic                           en_sum,
	input  wire logic [VALUE_BITS-1:0]          a,
	input  wire logic [VALUE_BITS-1:0]          b,
	input  wire logic [its_pkg::FRAC_BITS-1:0]  t,
	output logic      [VALUE_BITS-1:0]          res
);

	import its_pkg::*;

	localparam int PA_W = VALUE_BITS + FRAC_BITS + 1;
	localparam int PB_W = VALUE_BITS + FRAC_BITS;
	localparam int SUM_W = PA_W + 1;
	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;
	localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

	logic [FRAC_BITS:0] w;
	logic [PA_W-1:0]    pa_s4;
	logic [PB_W-1:0]    pb_s4;
	logic [SUM_W-1:0]   sum;
	logic [VALUE_BITS-1:0] res_q;

	assign w = ONE - (FRAC_BITS + 1)'(t);

	always_ff @(posedge clk) begin
		if (en_mul) begin
			pa_s4 <= PA_W'(a) * PA_W'(w);
			pb_s4 <= PB_W'(b) * PB_W'(t);
		end
	end

	assign sum = SUM_W'(pa_s4) + SUM_W'(pb_s4) + HALF;

	always_ff @(posedge clk) begin
		if (en_sum) begin
			res_q <= sum[FRAC_BITS +: VALUE_BITS];
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// testbench for the interpolated table sampler: stream driver, result checker and predictor
`timescale 1ns / 1ps

module tb_top;
	import its_pkg::*;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int SETTLE_CYCLES = 12;
	localparam int TABLE_DEPTH   = DEF_MAX_ENTRIES;
	localparam int FILL_ENTRIES  = 512;
	localparam int ITEMS_PER_RUN = 24;

	typedef struct {
		logic [SAMPLE_W-1:0] x;
		logic [SAMPLE_W-1:0] y;
		logic [SAMPLE_W-1:0] z;
		clamp_t              clamp;
	} sample_t;

	// keeps its own copy of the table and registers, predicts each sample
	class sample_checker;
		logic [SAMPLE_W-1:0] lut_x [TABLE_DEPTH];
		logic [SAMPLE_W-1:0] lut_y [TABLE_DEPTH];
		logic [SAMPLE_W-1:0] lut_z [TABLE_DEPTH];
		logic [WL_W-1:0]     start_wl;
		logic [WL_W-1:0]     end_wl;
		logic [COUNT_W-1:0]  count;
		logic [SCALE_W-1:0]  scale;
		sample_t             expected_samples [$];
		int                  mismatches;

		function new();
			start_wl   = RST_START;
			end_wl     = RST_END;
			count      = RST_COUNT;
			scale      = RST_SCALE;
			mismatches = 0;
		endfunction

		function void set_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
			case (r)
				REG_START: start_wl = v[WL_W-1:0];
				REG_END:   end_wl   = v[WL_W-1:0];
				REG_COUNT: count    = v[COUNT_W-1:0];
				default:   scale    = v[SCALE_W-1:0];
			endcase
		endfunction

		// round half up blend of two neighbours
		function logic [SAMPLE_W-1:0] blend(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
				logic [FRAC_BITS-1:0] t);
			logic [63:0] acc;
			acc = 64'(a) * ((64'd1 << FRAC_BITS) - 64'(t)) + 64'(b) * 64'(t)
				+ (64'd1 << (FRAC_BITS - 1));
			return acc[FRAC_BITS +: SAMPLE_W];
		endfunction

		function sample_t entry_of(int unsigned i, clamp_t c);
			sample_t s;
			s.x     = lut_x[i];
			s.y     = lut_y[i];
			s.z     = lut_z[i];
			s.clamp = c;
			return s;
		endfunction

		function sample_t interpolate(logic [WL_W-1:0] wl);
			sample_t             s;
			int unsigned         n;
			int unsigned         last;
			logic [WL_W-1:0]     diff;
			logic [PROD_W-1:0]   prod;
			logic [IPART_W-1:0]  idx;
			logic [FRAC_BITS-1:0] t;
			n = count;
			if (n > TABLE_DEPTH) n = TABLE_DEPTH;
			if (n == 0) n = 1;
			last = n - 1;
			if (wl < start_wl) return entry_of(0, CLAMP_BELOW);
			if (wl > end_wl) return entry_of(last, CLAMP_LAST);
			diff = wl - start_wl;
			prod = {{SCALE_W{1'b0}}, diff} * {{WL_W{1'b0}}, scale};
			idx  = prod[PROD_W-1:FRAC_BITS];
			t    = prod[FRAC_BITS-1:0];
			if (idx >= last) return entry_of(last, CLAMP_LAST);
			s.x     = blend(lut_x[idx], lut_x[idx + 1], t);
			s.y     = blend(lut_y[idx], lut_y[idx + 1], t);
			s.z     = blend(lut_z[idx], lut_z[idx + 1], t);
			s.clamp = CLAMP_NONE;
			return s;
		endfunction

		function void note_word(logic kind, logic [IN_TDATA_W-1:0] d);
			logic [ENTRY_IDX_W-1:0] e;
			if (kind == KIND_LOAD) begin
				e        = d[WL_W +: ENTRY_IDX_W];
				lut_x[e] = d[26 +: LOAD_W];
				lut_y[e] = d[42 +: LOAD_W];
				lut_z[e] = d[58 +: LOAD_W];
			end else begin
				expected_samples = {expected_samples, interpolate(d[WL_W-1:0])};
			end
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] d, logic [CLAMP_W-1:0] u);
			sample_t e;
			if (expected_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word x=%h y=%h z=%h clamp=%0d",
						d[15:0], d[31:16], d[47:32], u);
				return;
			end
			e = expected_samples.pop_front();
			if (d[15:0] !== e.x || d[31:16] !== e.y || d[47:32] !== e.z || u !== e.clamp) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected x=%h y=%h z=%h clamp=%0d, got x=%h y=%h z=%h clamp=%0d",
						e.x, e.y, e.z, e.clamp, d[15:0], d[31:16], d[47:32], u);
			end
		endfunction

		function int pending();
			return expected_samples.size();
		endfunction
	endclass

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   cfg_we        = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_data      = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   s_axis_tuser  = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [CLAMP_W-1:0]     m_axis_tuser;

	sample_checker sb;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request  = 0;
	int hold_left     = 0;
	int cycle_count   = 0;

	interpolated_table_sampler_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	function automatic logic [IN_TDATA_W-1:0] pack_word(logic [WL_W-1:0] wl,
			logic [ENTRY_IDX_W-1:0] e, logic [LOAD_W-1:0] x, logic [LOAD_W-1:0] y,
			logic [LOAD_W-1:0] z);
		return {6'd0, z, y, x, e, wl};
	endfunction

	function automatic logic [LOAD_W-1:0] rand_value();
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return LOAD_W'($urandom);
	endfunction

	// mostly inside the table range, some near the ends, some anywhere
	function automatic logic [WL_W-1:0] pick_wavelength(logic [WL_W-1:0] st, logic [WL_W-1:0] en);
		int unsigned r;
		int          v;
		r = $urandom_range(99);
		if (r < 10) return WL_W'($urandom);
		if (r < 22) begin
			v = ((r < 16) ? int'(st) : int'(en)) + int'($urandom_range(4)) - 2;
			if (v < 0) v = 0;
			if (v > 65535) v = 65535;
			return WL_W'(v);
		end
		return WL_W'($urandom_range(en, st));
	endfunction

	function automatic logic [SCALE_W-1:0] matched_scale(logic [WL_W-1:0] st, logic [WL_W-1:0] en,
			logic [COUNT_W-1:0] cnt);
		longint unsigned n;
		n = cnt;
		if (n > TABLE_DEPTH) n = TABLE_DEPTH;
		if (n == 0) n = 1;
		if (en <= st) return SCALE_W'($urandom);
		n = ((n - 1) << FRAC_BITS) / (en - st);
		if (n > 24'hFFFFFF) n = 24'hFFFFFF;
		return n[SCALE_W-1:0];
	endfunction

	task automatic send_word(input logic kind, input logic [IN_TDATA_W-1:0] word);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		s_axis_tuser  <= kind;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_word(kind, word);
	endtask

	task automatic load_entry(input logic [ENTRY_IDX_W-1:0] e, input logic [LOAD_W-1:0] x,
			input logic [LOAD_W-1:0] y, input logic [LOAD_W-1:0] z);
		send_word(KIND_LOAD, pack_word(WL_W'($urandom), e, x, y, z));
	endtask

	task automatic sample_at(input logic [WL_W-1:0] wl);
		send_word(KIND_SAMPLE, pack_word(wl, ENTRY_IDX_W'($urandom), LOAD_W'($urandom),
			LOAD_W'($urandom), LOAD_W'($urandom)));
	endtask

	// stop offering, wait for every result, then let trailing loads leave the pipe
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [WL_W-1:0] st, input logic [WL_W-1:0] en,
			input logic [COUNT_W-1:0] cnt, input logic [SCALE_W-1:0] sc);
		cfg_reg_t              r;
		logic [CFG_DATA_W-1:0] v;
		for (int i = 0; i < 4; i++) begin
			r = cfg_reg_t'(i);
			case (r)
				REG_START: v = CFG_DATA_W'(st);
				REG_END:   v = CFG_DATA_W'(en);
				REG_COUNT: v = CFG_DATA_W'(cnt);
				default:   v = sc;
			endcase
			cfg_we    <= 1'b1;
			cfg_index <= r;
			cfg_data  <= v;
			@(posedge clk);
			sb.set_reg(r, v);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input int p, input logic [WL_W-1:0] st, input logic [WL_W-1:0] en,
			input logic [COUNT_W-1:0] cnt, input logic [SCALE_W-1:0] sc);
		logic kind;
		settle();
		configure(st, en, cnt, sc);
		case (p % 4)
			0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
			1: begin send_idle_pct = 82; recv_idle_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_idle_pct = 82; end
			default: begin send_idle_pct = 24; recv_idle_pct = 24; end
		endcase
		// long receiver hold-off while words keep coming, so the pipe backs up
		if (p == 4) hold_request = 300;
		for (int i = 0; i < ITEMS_PER_RUN; i++) begin
			kind = ($urandom_range(99) < 25) ? KIND_LOAD : KIND_SAMPLE;
			if (kind == KIND_LOAD)
				load_entry(ENTRY_IDX_W'($urandom), rand_value(), rand_value(), rand_value());
			else
				sample_at(pick_wavelength(st, en));
		end
	endtask

	initial begin
		logic [WL_W-1:0] rs;
		logic [WL_W-1:0] re;
		logic [COUNT_W-1:0] rc;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the entries that the runs use, so that no sample reads an unwritten entry
		for (int i = 0; i < FILL_ENTRIES; i++)
			load_entry(ENTRY_IDX_W'(i), LOAD_W'($urandom), LOAD_W'($urandom), LOAD_W'($urandom));

		// directed: reset registers, unit scale, extreme values next to each other
		load_entry(ENTRY_IDX_W'(0), 16'hFFFF, 16'hFFFF, 16'hFFFF);
		load_entry(ENTRY_IDX_W'(1), 16'h0000, 16'h0000, 16'h0000);
		load_entry(ENTRY_IDX_W'(2), 16'h0000, 16'hFFFF, 16'h8000);
		load_entry(ENTRY_IDX_W'(1023), 16'hFFFF, 16'h0000, 16'hFFFF);
		sample_at(16'd0);
		sample_at(16'd23039);
		sample_at(16'd23040);
		sample_at(16'd23041);
		sample_at(16'd23509);
		sample_at(16'd53120);
		sample_at(16'd53121);
		sample_at(16'hFFFF);
		settle();

		// small table with a fractional scale; end itself stays interpolated
		configure(16'd100, 16'd740, 11'd10, matched_scale(16'd100, 16'd740, 11'd10));
		sample_at(16'd99);
		sample_at(16'd100);
		sample_at(16'd101);
		sample_at(16'd133);
		sample_at(16'd740);
		sample_at(16'd741);
		settle();

		// zero count: only entry 0 is in use
		configure(16'd100, 16'd740, 11'd0, 24'd7372);
		sample_at(16'd300);
		sample_at(16'd50);
		settle();

		// start above end, count beyond the table
		configure(16'd5000, 16'd100, 11'd2047, 24'd7372);
		sample_at(16'd3000);
		sample_at(16'd5000);
		sample_at(16'd6000);

		// random runs over a spread of register settings
		run_phase(0, RST_START, RST_END, RST_COUNT, RST_SCALE);
		run_phase(1, 16'd0, 16'hFFFF, 11'd512, matched_scale(16'd0, 16'hFFFF, 11'd512));
		// saturated count, scale kept inside the filled entries
		run_phase(2, 16'd0, 16'hFFFF, 11'd2047, matched_scale(16'd0, 16'hFFFF, 11'd511));
		run_phase(3, 16'd30000, 16'd30100, 11'd10, matched_scale(16'd30000, 16'd30100, 11'd10));
		run_phase(4, 16'd2000, 16'd50000, 11'd300, matched_scale(16'd2000, 16'd50000, 11'd300));
		run_phase(5, 16'd0, 16'hFFFF, 11'd512, 24'hFFFFFF);
		run_phase(6, 16'd1234, 16'd40000, 11'd500, 24'd0);
		run_phase(7, 16'd5000, 16'd4000, 11'd64, SCALE_W'($urandom));
		rs = WL_W'($urandom_range(30000));
		re = rs + WL_W'($urandom_range(35000));
		rc = COUNT_W'($urandom_range(FILL_ENTRIES));
		run_phase(8, rs, re, rc, matched_scale(rs, re, rc));

		send_idle_pct = 0;
		recv_idle_pct = 0;
		settle();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
